// ===== rtl/pd_turn_to_heading_assert.svh =====
// assertion macros for the turn-to-heading controller
`ifndef PD_TURN_TO_HEADING_ASSERT_SVH
`define PD_TURN_TO_HEADING_ASSERT_SVH

// same-cycle implication, checked on every clock edge outside reset
`define PD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pd_turn_to_heading assertion failed");

// next-cycle implication, checked on every clock edge outside reset
`define PD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pd_turn_to_heading assertion failed");

`endif

// ===== rtl/pdtth_pkg.sv =====
// shared types and constants for the turn-to-heading controller
`default_nettype none

package pdtth_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_TARGET_ANGLE = 3'd0;
    localparam logic [2:0] CFG_P_GAIN       = 3'd1;
    localparam logic [2:0] CFG_D_GAIN       = 3'd2;
    localparam logic [2:0] CFG_SETTLE_BAND  = 3'd3;
    localparam logic [2:0] CFG_SETTLE_TICKS = 3'd4;

    // result phase codes
    localparam logic [1:0] PHASE_DRIVE = 2'd0;
    localparam logic [1:0] PHASE_BRAKE = 2'd1;
    localparam logic [1:0] PHASE_STOP  = 2'd2;

    // move timeout in ticks
    localparam logic [8:0] TICK_LIMIT = 9'd263;

    // speed shaping
    localparam logic signed [27:0] SPEED_MAX  = 28'sd127;
    localparam logic signed [27:0] SPEED_SLOW = 28'sd30;
    localparam logic signed [7:0]  SPEED_MIN  = 8'sd25;

    typedef logic signed [16:0] err_t;
    typedef logic signed [17:0] diff_t;
    typedef logic signed [33:0] pprod_t;
    typedef logic signed [34:0] dprod_t;
    typedef logic signed [35:0] sum_t;

endpackage

`default_nettype wire

// ===== rtl/pd_turn_to_heading.sv =====
// pd turn-to-heading controller: error, pd terms, clamp, drive/brake/stop requests
// an accepted tick passes stage 1, stage 2, stage 3 and the result register before its drive request on the m_ side
// throughput: one tick per cycle while m_tready is high; a tick that ends the move holds the result
//   register through its drive, brake and stop beats, which stalls the ticks behind it
// pipeline: error/state update, two multipliers, sum, divide-by-256 and clamp
// reset (aresetn low, synchronous): registers to defaults, move active, pipeline empty
`default_nettype none

module pd_turn_to_heading
    import pdtth_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // tick input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,    // [15:0] gyro_angle, [16] begin_move, rest zero
    // command output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,    // [7:0] right_speed
    output logic [1:0]       m_tuser,    // [1:0] phase
    output logic             m_tlast,    // last
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // configuration
    logic signed [15:0] target_reg;
    logic [15:0]        p_gain_reg;
    logic [15:0]        d_gain_reg;
    logic [15:0]        band_reg;
    logic [15:0]        ticks_reg;

    // loop state
    diff_t       prev_reg;
    logic [15:0] settled_reg;
    logic [8:0]  tick_reg;
    logic        active_reg;

    // pipeline
    logic   s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    err_t   s1_err_reg;
    diff_t  s1_diff_reg;
    logic   s1_done_reg, s2_done_reg, s3_done_reg, out_done_reg;
    pprod_t s2_pprod_reg;
    dprod_t s2_dprod_reg;
    sum_t   s3_sum_reg;
    logic signed [7:0] out_speed_reg;
    logic [1:0]        out_beat_reg;

    // front-end logic
    logic signed [15:0] gyro;
    logic               begin_move;
    diff_t              prev_eff;
    logic [15:0]        settled_eff;
    logic [8:0]         tick_eff;
    logic               active_eff;
    err_t               err;
    diff_t              diff;
    logic [16:0]        mag;
    logic               settled;
    logic [15:0]        settled_next;
    logic [8:0]         tick_next;
    logic               done;
    logic               accept;
    logic               take;

    // flow control
    logic out_last;
    logic out_free;
    logic s3_ready, s2_ready, s1_ready;

    // arithmetic
    pprod_t pprod_next;
    dprod_t dprod_next;
    sum_t   sum_next;
    logic signed [27:0] quot;
    logic signed [7:0]  speed_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            p_gain_reg <= 16'd256;
            d_gain_reg <= '0;
            band_reg   <= 16'd1;
            ticks_reg  <= 16'd1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_TARGET_ANGLE: target_reg <= cfg_data;
                CFG_P_GAIN:       p_gain_reg <= cfg_data;
                CFG_D_GAIN:       d_gain_reg <= cfg_data;
                CFG_SETTLE_BAND:  band_reg   <= cfg_data;
                CFG_SETTLE_TICKS: ticks_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // error, settle and timeout decision for the incoming tick
    always_comb begin
        gyro        = s_tdata[15:0];
        begin_move  = s_tdata[16];
        prev_eff    = begin_move ? '0 : prev_reg;
        settled_eff = begin_move ? '0 : settled_reg;
        tick_eff    = begin_move ? '0 : tick_reg;
        active_eff  = begin_move || active_reg;
        err         = err_t'(target_reg) - err_t'(gyro);
        diff        = diff_t'(err) - prev_eff;
        mag         = err[16] ? 17'(-err) : 17'(err);
        settled     = mag < {1'b0, band_reg};
        settled_next = (settled && settled_eff != 16'hFFFF) ? settled_eff + 16'd1
                                                             : settled_eff;
        tick_next   = tick_eff + 9'd1;
        done        = (settled && settled_next >= ticks_reg) || (tick_next >= TICK_LIMIT);
    end

    assign out_last = out_done_reg ? (out_beat_reg == PHASE_STOP) : 1'b1;
    assign out_free = !out_valid_reg || (m_tready && out_last);
    assign s3_ready = !s3_valid_reg || out_free;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_tready = s1_ready;
    assign accept   = s_tvalid && s_tready;
    // an idle tick is accepted but never enters the pipeline
    assign take     = accept && active_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg    <= '0;
            settled_reg <= '0;
            tick_reg    <= '0;
            active_reg  <= 1'b1;
        end else if (take) begin
            prev_reg    <= done ? prev_eff : diff_t'(err);
            settled_reg <= settled_next;
            tick_reg    <= tick_next;
            active_reg  <= !done;
        end
    end

    // stage 1: error and difference
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_err_reg  <= err;
            s1_diff_reg <= diff;
            s1_done_reg <= done;
        end
    end

    // stage 2: gain products
    assign pprod_next = pprod_t'($signed({1'b0, p_gain_reg})) * pprod_t'(s1_err_reg);
    assign dprod_next = dprod_t'($signed({1'b0, d_gain_reg})) * dprod_t'(s1_diff_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready) begin
            s2_pprod_reg <= pprod_next;
            s2_dprod_reg <= dprod_next;
            s2_done_reg  <= s1_done_reg;
        end
    end

    // stage 3: pd sum
    assign sum_next = sum_t'(s2_pprod_reg) + sum_t'(s2_dprod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_ready) begin
            s3_sum_reg  <= sum_next;
            s3_done_reg <= s2_done_reg;
        end
    end

    // divide by 256 toward zero, clamp, set speeds below the slow limit to the minimum
    always_comb begin
        quot = s3_sum_reg[35:8] + 28'(s3_sum_reg[35] && (s3_sum_reg[7:0] != 8'd0));
        if (quot > SPEED_MAX) begin
            speed_next = 8'(SPEED_MAX);
        end else if (quot < -SPEED_MAX) begin
            speed_next = 8'(-SPEED_MAX);
        end else if (quot > -SPEED_SLOW && quot < SPEED_SLOW) begin
            speed_next = quot[27] ? -SPEED_MIN : SPEED_MIN;
        end else begin
            speed_next = quot[7:0];
        end
    end

    // result register, steps through drive, brake, stop on an ending tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_beat_reg  <= PHASE_DRIVE;
        end else if (s3_valid_reg && out_free) begin
            out_valid_reg <= 1'b1;
            out_beat_reg  <= PHASE_DRIVE;
        end else if (out_valid_reg && m_tready) begin
            if (out_last) begin
                out_valid_reg <= 1'b0;
            end else begin
                unique case (out_beat_reg)
                    PHASE_DRIVE: out_beat_reg <= PHASE_BRAKE;
                    PHASE_BRAKE: out_beat_reg <= PHASE_STOP;
                    default:     out_beat_reg <= PHASE_STOP;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_valid_reg && out_free) begin
            out_speed_reg <= speed_next;
            out_done_reg  <= s3_done_reg;
        end
    end

    always_comb begin
        unique case (out_beat_reg)
            PHASE_DRIVE: m_tdata = out_speed_reg;
            PHASE_BRAKE: m_tdata = 8'(-out_speed_reg);
            default:     m_tdata = '0;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_beat_reg;
    assign m_tlast  = out_last;

`include "pd_turn_to_heading_assert.svh"

    `PD_ASSERT_SAME(a_brake_not_last, m_tvalid && m_tuser == PHASE_BRAKE, !m_tlast)
    `PD_ASSERT_SAME(a_stop_is_zero_last, m_tvalid && m_tuser == PHASE_STOP,
                    m_tlast && m_tdata == 8'd0)
    `PD_ASSERT_NEXT(a_drive_then_brake, m_tvalid && m_tready && m_tuser == PHASE_DRIVE && !m_tlast,
                    m_tvalid && m_tuser == PHASE_BRAKE)

endmodule

`default_nettype wire
